/* src/gray_histogram_with_roi_macros.svh */
// ----------------------------------------------------------------------------
// gray histogram assertion macros
// shared concurrent assertion forms for the histogram block
// ----------------------------------------------------------------------------
`ifndef GRAY_HISTOGRAM_WITH_ROI_MACROS_SVH
`define GRAY_HISTOGRAM_WITH_ROI_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GHIST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GHIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ghist_pkg.sv */
// ----------------------------------------------------------------------------
// ghist_pkg
// types and constants shared by the gray histogram modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghist_pkg;

  localparam int BIN_COUNT      = 256;
  localparam int BIN_BITS       = $clog2(BIN_COUNT);
  localparam int COUNT_BITS     = 32;
  localparam int OUT_COUNT_BITS = 32;
  localparam int COORD_BITS     = 12;
  localparam int DIM_BITS       = COORD_BITS + 1;
  localparam int CHAN_BITS      = 8;
  localparam int FMT_BITS       = 2;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = DIM_BITS;

  // luma = (299 r + 587 g + 114 b) / 1000, division by reciprocal
  localparam int LUMA_R_COEF = 299;
  localparam int LUMA_G_COEF = 587;
  localparam int LUMA_B_COEF = 114;
  localparam int SUM_BITS    = 18;
  localparam int LUMA_SHIFT  = 28;
  localparam int LUMA_RECIP  = ((1 << LUMA_SHIFT) + 999) / 1000;
  localparam int PROD_BITS   = SUM_BITS + 19;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PIXEL_FORMAT = 3'd0,
    CFG_ROI_ENABLE   = 3'd1,
    CFG_ROI_LEFT     = 3'd2,
    CFG_ROI_TOP      = 3'd3,
    CFG_ROI_RIGHT    = 3'd4,
    CFG_ROI_BOTTOM   = 3'd5,
    CFG_IMAGE_WIDTH  = 3'd6,
    CFG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam logic [FMT_BITS-1:0] FMT_GRAY8 = 2'd0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [CHAN_BITS-1:0]  bin_select;
    logic [CHAN_BITS-1:0]  chan_c;
    logic [CHAN_BITS-1:0]  chan_b;
    logic [CHAN_BITS-1:0]  chan_a;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_x;
  } in_data_t;

  localparam int IN_DATA_BITS = $bits(in_data_t);

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic [BIN_BITS-1:0]       gray_level;
  } out_data_t;

  localparam int OUT_DATA_BITS = $bits(out_data_t);

  typedef struct packed {
    logic                en;
    logic [BIN_BITS-1:0] addr;
    count_t              data;
  } bin_wr_t;

endpackage

/* src/ghist_bins.sv */
// ----------------------------------------------------------------------------
// ghist_bins
// bin count memory with valid bits and same-edge write forwarding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gray_histogram_with_roi_macros.svh"

module ghist_bins (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [ghist_pkg::BIN_BITS-1:0] rd_addr,
  input  ghist_pkg::bin_wr_t            wr,
  output ghist_pkg::count_t             rd_value
);

  ghist_pkg::count_t mem [ghist_pkg::BIN_COUNT];
  ghist_pkg::count_t rd_data;
  ghist_pkg::count_t fwd_data;
  logic [ghist_pkg::BIN_COUNT-1:0] vbits;
  logic vhit;
  logic fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits   <= '0;
      vhit    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        vbits[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vhit    <= vbits[rd_addr];
        fwd_hit <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rd_value = fwd_data;
    end else if (vhit) begin
      rd_value = rd_data;
    end else begin
      rd_value = '0;
    end
  end

  `GHIST_ASSERT_SAME(a_wr_with_rd, clk, rst, wr.en, rd_en, "write without read")
  `GHIST_ASSERT_NEXT(a_fwd_same_addr, clk, rst, rd_en && wr.en && (wr.addr == rd_addr), fwd_hit, "forward miss")
  `GHIST_ASSERT_NEXT(a_hold_value, clk, rst, !rd_en && !rst, $stable(rd_value), "read value moved")

endmodule

/* src/gray_histogram_with_roi.sv */
// ----------------------------------------------------------------------------
// gray_histogram_with_roi
// 256-bin grey-level histogram with region of interest and bin readout
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request per transaction: tuser selects pixel or read,
//   tdata carries position, channels and bin index. m_axis returns exactly
//   one result transaction per request, in order.
//   cfg_we/cfg_index/cfg_data write the format and region registers; write
//   them only while no request is in flight.
// pipeline: a request passes stage 1 (luma sum), stage 2 (reciprocal
//   multiply), stage 3 (bin read) and then the update into the output
//   register.
// throughput: one request per cycle while m_axis is not stalled; each cycle
//   the bin memory does at most one read and one write, and a write to the bin just read is forwarded.
// reset: sets config and valid registers to defaults and marks every bin empty
//   at once through per-bin valid bits, so requests are taken from the first cycle.
// stall: when m_axis_tready is low the result holds in the output register;
//   the pipeline keeps filling its empty stages and then lowers
//   s_axis_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gray_histogram_with_roi_macros.svh"

module gray_histogram_with_roi (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, chan_a, chan_b, chan_c, bin_select
  input  logic [ghist_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // req_type
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // gray_level, bin_count
  output logic [ghist_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // was_counted
  output logic [0:0]                            m_axis_tuser,
  input  logic                                  cfg_we,
  input  logic [ghist_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ghist_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // configuration
  logic [ghist_pkg::FMT_BITS-1:0]   pixel_format;
  logic                             roi_enable;
  logic [ghist_pkg::COORD_BITS-1:0] roi_left;
  logic [ghist_pkg::COORD_BITS-1:0] roi_top;
  logic [ghist_pkg::COORD_BITS-1:0] roi_right;
  logic [ghist_pkg::COORD_BITS-1:0] roi_bottom;
  logic [ghist_pkg::DIM_BITS-1:0]   image_width;
  logic [ghist_pkg::DIM_BITS-1:0]   image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= ghist_pkg::FMT_GRAY8;
      roi_enable   <= 1'b0;
      roi_left     <= '0;
      roi_top      <= '0;
      roi_right    <= '1;
      roi_bottom   <= '1;
      image_width  <= ghist_pkg::DIM_BITS'(1 << ghist_pkg::COORD_BITS);
      image_height <= ghist_pkg::DIM_BITS'(1 << ghist_pkg::COORD_BITS);
    end else if (cfg_we) begin
      unique case (ghist_pkg::cfg_reg_t'(cfg_index))
        ghist_pkg::CFG_PIXEL_FORMAT: begin
          pixel_format <= cfg_data[ghist_pkg::FMT_BITS-1:0];
        end
        ghist_pkg::CFG_ROI_ENABLE: begin
          roi_enable <= cfg_data[0];
        end
        ghist_pkg::CFG_ROI_LEFT: begin
          roi_left <= cfg_data[ghist_pkg::COORD_BITS-1:0];
        end
        ghist_pkg::CFG_ROI_TOP: begin
          roi_top <= cfg_data[ghist_pkg::COORD_BITS-1:0];
        end
        ghist_pkg::CFG_ROI_RIGHT: begin
          roi_right <= cfg_data[ghist_pkg::COORD_BITS-1:0];
        end
        ghist_pkg::CFG_ROI_BOTTOM: begin
          roi_bottom <= cfg_data[ghist_pkg::COORD_BITS-1:0];
        end
        ghist_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[ghist_pkg::DIM_BITS-1:0];
        end
        ghist_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[ghist_pkg::DIM_BITS-1:0];
        end
      endcase
    end
  end

  // pipeline flow control
  logic out_en;
  logic en3;
  logic en2;
  logic en1;
  logic v1;
  logic v2;
  logic v3;

  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign en3           = !v3 || out_en;
  assign en2           = !v2 || en3;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;

  // input stage: region test and luma sum
  ghist_pkg::in_data_t in_d;
  logic region_on;
  logic in_box;
  logic [ghist_pkg::SUM_BITS-1:0] luma_sum;

  assign in_d = s_axis_tdata;

  assign region_on = roi_enable && (roi_left <= roi_right) && (roi_top <= roi_bottom)
                     && ({1'b0, roi_left} < image_width) && ({1'b0, roi_top} < image_height);

  assign in_box = (in_d.pos_x >= roi_left) && (in_d.pos_x <= roi_right)
                  && ({1'b0, in_d.pos_x} < image_width)
                  && (in_d.pos_y >= roi_top) && (in_d.pos_y <= roi_bottom)
                  && ({1'b0, in_d.pos_y} < image_height);

  assign luma_sum =
      ghist_pkg::SUM_BITS'(ghist_pkg::LUMA_R_COEF) * ghist_pkg::SUM_BITS'(in_d.chan_a)
    + ghist_pkg::SUM_BITS'(ghist_pkg::LUMA_G_COEF) * ghist_pkg::SUM_BITS'(in_d.chan_b)
    + ghist_pkg::SUM_BITS'(ghist_pkg::LUMA_B_COEF) * ghist_pkg::SUM_BITS'(in_d.chan_c);

  logic                              req1;
  logic                              direct1;
  logic                              counted1;
  logic [ghist_pkg::BIN_BITS-1:0]    key1;
  logic [ghist_pkg::SUM_BITS-1:0]    sum1;

  always_ff @(posedge clk) begin
    if (en1) begin
      req1     <= s_axis_tuser[0];
      direct1  <= (s_axis_tuser[0] == ghist_pkg::REQ_READ) || (pixel_format == ghist_pkg::FMT_GRAY8);
      counted1 <= !region_on || in_box;
      key1     <= (s_axis_tuser[0] == ghist_pkg::REQ_READ) ? in_d.bin_select : in_d.chan_a;
      sum1     <= luma_sum;
    end
  end

  // stage 2: divide by 1000 through the reciprocal, or use the key directly for reads and gray8 pixels
  logic [ghist_pkg::PROD_BITS-1:0] luma_prod;
  logic [ghist_pkg::BIN_BITS-1:0]  bin_addr;

  assign luma_prod = ghist_pkg::PROD_BITS'(sum1) * ghist_pkg::PROD_BITS'(ghist_pkg::LUMA_RECIP);
  assign bin_addr  = direct1 ? key1 : luma_prod[ghist_pkg::LUMA_SHIFT +: ghist_pkg::BIN_BITS];

  logic                           counted2;
  logic [ghist_pkg::BIN_BITS-1:0] addr2;

  always_ff @(posedge clk) begin
    if (en2) begin
      counted2 <= counted1 && (req1 != ghist_pkg::REQ_READ);
      addr2    <= bin_addr;
    end
  end

  // stage 3: bin read, saturating update, write back
  logic                           counted3;
  logic [ghist_pkg::BIN_BITS-1:0] addr3;
  ghist_pkg::count_t              old_count;
  ghist_pkg::count_t              new_count;
  ghist_pkg::bin_wr_t             bin_wr;
  logic                           bump;

  always_ff @(posedge clk) begin
    if (en3) begin
      counted3 <= counted2;
      addr3    <= addr2;
    end
  end

  ghist_bins u_bins (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (en3),
    .rd_addr  (addr2),
    .wr       (bin_wr),
    .rd_value (old_count)
  );

  assign bump        = counted3 && (old_count != ghist_pkg::COUNT_MAX);
  assign new_count   = bump ? old_count + ghist_pkg::count_t'(1) : old_count;
  assign bin_wr.en   = v3 && out_en && bump;
  assign bin_wr.addr = addr3;
  assign bin_wr.data = new_count;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_axis_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (out_en) begin
        m_axis_tvalid <= v3;
      end
    end
  end

  // output register
  ghist_pkg::out_data_t out_d;

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_d.gray_level <= addr3;
      out_d.bin_count  <= ghist_pkg::OUT_COUNT_BITS'(new_count);
      m_axis_tuser[0]  <= counted3;
    end
  end

  assign m_axis_tdata = out_d;

  `GHIST_ASSERT_SAME(a_counted_nonzero, clk, rst, m_axis_tvalid && m_axis_tuser[0], out_d.bin_count != '0, "counted bin reads zero")
  `GHIST_ASSERT_NEXT(a_stage3_holds, clk, rst, v3 && m_axis_tvalid && !m_axis_tready, v3 && $stable(addr3), "stage 3 lost item")
  `GHIST_ASSERT_SAME(a_write_only_moving, clk, rst, bin_wr.en, v3 && out_en && counted3, "stray bin write")

endmodule
